// ===== hdl/tree_nearest_resource_min_cost_assign_core_assert.svh =====
// Assertion macros shared by the tree assignment block.
`ifndef TREE_NEAREST_RESOURCE_MIN_COST_ASSIGN_CORE_ASSERT_SVH
`define TREE_NEAREST_RESOURCE_MIN_COST_ASSIGN_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define TNA_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequence is checked in the cycle after the antecedent.
`define TNA_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hdl/tna_pkg.sv =====
// Package: constants, state codes and memory word type for the tree assignment block.
`timescale 1ns / 1ps
package tna_pkg;
    localparam int NodeW = 10;
    localparam int MaxNodes = 1023;
    localparam int CapW = 16;
    localparam int FlowW = 32;
    localparam int CostW = 8;
    localparam int TotW = 32;
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_REQ = 1'b1;

    typedef struct packed {
        logic [CapW-1:0] slots;
        logic [FlowW-1:0] flow;
        logic bvalid;
        logic signed [CostW-1:0] bcost;
        logic [NodeW-1:0] bnode;
    } node_word_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE,
        ST_RB_SET, ST_RB_RD,
        ST_LD_RD, ST_LD_WR,
        ST_RQ_RD, ST_RQ_EVAL, ST_RQ_DEC,
        ST_PT_STEP, ST_PT_RD,
        ST_RF_RD, ST_RF_C0, ST_RF_C1, ST_RF_WR,
        ST_OUT
    } state_t;
endpackage

// ===== hdl/tree_nearest_resource_min_cost_assign_core.sv =====
// Top level: tree-based online minimum cost assignment engine.
//
// Channel  | Dir | Contents
// s_axis   | in  | tdata: node[9:0], capacity[25:10], zero pad to 32; tuser: func
// m_axis   | out | tdata: cost[4:0], total[36:5], served_node[46:37], zero pad to 48;
//          |     | tuser: none_free
// cfg      | in  | cfg_we/cfg_wdata: node_count
//
// After reset a clearing pass walks all 1024 words of the node memory; no beat is taken meanwhile.
// Each node refresh is a read of the node, then of each child, then a write; during a load or
// request a path step state lies between refreshes.
// A load writes the node's capacity and refreshes it and each ancestor; a request searches the
// path to the root, takes the slot and refreshes the nodes on both repair paths.
// A node_count write rebuilds every node bottom-up.
// One item is worked at a time; a new beat may be taken while a result waits on m_axis,
// and the next result is held back until that one has gone.
`timescale 1ns / 1ps
module tree_nearest_resource_min_cost_assign_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // node, capacity, pad
    input  logic        s_axis_tuser,  // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // cost, total, served_node, pad
    output logic        m_axis_tuser,  // none_free
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata
);
    import tna_pkg::*;
    `include "tree_nearest_resource_min_cost_assign_core_assert.svh"

    node_word_t mem [0:MaxNodes];
    node_word_t rd_q, wr_d;
    logic [NodeW-1:0] addr, wr_addr;
    logic wr_en;

    state_t state_reg, state_next, ret_reg, ret_next;
    logic [NodeW-1:0] n_reg, n_next, clr_reg, clr_next;
    logic cfg_pend_reg, cfg_pend_next;
    logic func_reg, func_next;
    logic [NodeW-1:0] node_reg, node_next, x_reg, x_next, cur_reg, cur_next, tgt_reg, tgt_next;
    logic [NodeW-1:0] ru_reg, ru_next;
    logic [CapW-1:0] cap_reg, cap_next;
    logic found_reg, found_next;
    logic signed [CostW-1:0] bc_reg, bc_next, climb_reg, climb_next;
    logic [NodeW-1:0] bn_reg, bn_next;
    logic [TotW-1:0] tot_reg, tot_next;
    node_word_t w_reg, w_next;
    logic signed [CostW-1:0] rc_reg, rc_next;
    logic [47:0] out_reg, out_next;
    logic nf_reg, nf_next;
    logic ov_reg, ov_next;
    logic [NodeW:0] ch;
    logic signed [CostW-1:0] cand;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_d;
        end
        rd_q <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ret_reg <= ST_IDLE;
            n_reg <= 10'd1023;
            clr_reg <= '0;
            cfg_pend_reg <= 1'b0;
            tot_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            n_reg <= n_next;
            clr_reg <= clr_next;
            cfg_pend_reg <= cfg_pend_next;
            tot_reg <= tot_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next; node_reg <= node_next; x_reg <= x_next;
        cur_reg <= cur_next; tgt_reg <= tgt_next; ru_reg <= ru_next;
        cap_reg <= cap_next; found_reg <= found_next; bc_reg <= bc_next;
        climb_reg <= climb_next; bn_reg <= bn_next; w_reg <= w_next;
        rc_reg <= rc_next;
        out_reg <= out_next; nf_reg <= nf_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE) && !cfg_pend_reg && !cfg_we;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = out_reg;
    assign m_axis_tuser = nf_reg;

    // Next state and datapath.
    always_comb
    begin
        state_next = state_reg; ret_next = ret_reg; n_next = n_reg; clr_next = clr_reg;
        cfg_pend_next = cfg_pend_reg; func_next = func_reg; node_next = node_reg;
        x_next = x_reg; cur_next = cur_reg; tgt_next = tgt_reg; ru_next = ru_reg;
        cap_next = cap_reg; found_next = found_reg; bc_next = bc_reg;
        climb_next = climb_reg; bn_next = bn_reg; tot_next = tot_reg; w_next = w_reg;
        rc_next = rc_reg;
        out_next = out_reg; nf_next = nf_reg; ov_next = ov_reg;
        addr = x_reg; wr_en = 1'b0; wr_addr = ru_reg; wr_d = w_reg;
        ch = '0; cand = '0;
        if (ov_reg && m_axis_tready)
        begin
            ov_next = 1'b0;
        end
        if (cfg_we)
        begin
            n_next = cfg_wdata;
            cfg_pend_next = 1'b1;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1; wr_addr = clr_reg; wr_d = '0;
                clr_next = clr_reg + 1'b1;
                rc_next = '0;
                if (clr_reg == NodeW'(MaxNodes))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cfg_pend_reg && !cfg_we)
                begin
                    cfg_pend_next = 1'b0;
                    x_next = n_reg;
                    state_next = (n_reg == '0) ? ST_IDLE : ST_RB_SET;
                end
                else if (s_axis_tvalid && s_axis_tready)
                begin
                    func_next = s_axis_tuser;
                    node_next = s_axis_tdata[9:0];
                    cap_next = s_axis_tdata[25:10];
                    x_next = s_axis_tdata[9:0];
                    found_next = 1'b0; bc_next = '0; bn_next = '0; climb_next = '0;
                    if (s_axis_tdata[9:0] == '0 || s_axis_tdata[9:0] > n_reg)
                    begin
                        if (s_axis_tuser == FUNC_REQ)
                        begin
                            state_next = ST_OUT;
                        end
                    end
                    else
                    begin
                        state_next = (s_axis_tuser == FUNC_LOAD) ? ST_LD_RD : ST_RQ_RD;
                    end
                end
            end
            ST_RB_SET:
            begin
                ru_next = x_reg; ret_next = ST_RB_RD; state_next = ST_RF_RD;
                addr = x_reg;
            end
            ST_RB_RD:
            begin
                x_next = x_reg - 1'b1;
                state_next = (x_reg == 10'd1) ? ST_IDLE : ST_RB_SET;
            end
            ST_LD_RD:
            begin
                addr = x_reg; state_next = ST_LD_WR;
            end
            ST_LD_WR:
            begin
                w_next = rd_q; w_next.slots = cap_reg;
                wr_en = 1'b1; wr_addr = x_reg; wr_d = w_next;
                cur_next = x_reg >> 1;
                ru_next = x_reg; ret_next = ST_PT_STEP; state_next = ST_RF_RD;
                cur_next = x_reg; tgt_next = x_reg;
            end
            ST_RQ_RD:
            begin
                addr = x_reg; state_next = ST_RQ_EVAL;
            end
            ST_RQ_EVAL:
            begin
                cand = rd_q.bcost + climb_reg;
                if (rd_q.bvalid && (!found_reg || cand <= bc_reg))
                begin
                    found_next = 1'b1; bc_next = cand; bn_next = rd_q.bnode;
                end
                climb_next = (rd_q.flow[FlowW-1] || rd_q.flow == '0) ?
                    climb_reg + 8'sd1 : climb_reg - 8'sd1;
                x_next = x_reg >> 1;
                if ((x_reg >> 1) == '0)
                begin
                    if (!found_next || bn_next == '0 || bn_next > n_reg)
                    begin
                        found_next = 1'b0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        x_next = bn_next; state_next = ST_RQ_DEC;
                    end
                end
                else
                begin
                    state_next = ST_RQ_RD;
                end
            end
            ST_RQ_DEC:
            begin
                // Wait state: read of the served node is issued here.
                addr = x_reg;
                cur_next = node_reg; tgt_next = bn_reg;
                ru_next = bn_reg; ret_next = ST_PT_STEP;
                tot_next = tot_reg + TotW'(bc_reg);
                state_next = ST_PT_RD;
            end
            ST_PT_RD:
            begin
                // Decrement the served node's slot count, then refresh it.
                w_next = rd_q;
                if (rd_q.slots != '0)
                begin
                    w_next.slots = rd_q.slots - 1'b1;
                end
                wr_en = 1'b1; wr_addr = bn_reg; wr_d = w_next;
                state_next = ST_PT_STEP;
            end
            ST_PT_STEP:
            begin
                // Walk both repair paths of a request; after they meet, refresh up to the root (a load walks one path).
                if (func_reg == FUNC_LOAD || cur_reg == tgt_reg)
                begin
                    if (func_reg == FUNC_LOAD)
                    begin
                        cur_next = cur_reg >> 1;
                        tgt_next = cur_reg >> 1;
                        if ((cur_reg >> 1) == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            ru_next = cur_reg >> 1; state_next = ST_RF_RD;
                        end
                    end
                    else if (cur_reg == '0)
                    begin
                        state_next = ST_OUT; found_next = 1'b1;
                    end
                    else
                    begin
                        ru_next = cur_reg; cur_next = cur_reg >> 1;
                        tgt_next = cur_reg >> 1; state_next = ST_RF_RD;
                    end
                end
                else if (cur_reg > tgt_reg)
                begin
                    ru_next = cur_reg; cur_next = cur_reg >> 1;
                    state_next = ST_RF_RD;
                end
                else
                begin
                    ru_next = tgt_reg; tgt_next = tgt_reg >> 1;
                    state_next = ST_RF_RD;
                end
                if (func_reg == FUNC_REQ && cur_reg != tgt_reg)
                begin
                    // Flow change folded into the refresh write, mark with rc.
                    rc_next = (cur_reg > tgt_reg) ? -8'sd1 : 8'sd1;
                end
                else
                begin
                    rc_next = '0;
                end
            end
            ST_RF_RD:
            begin
                addr = ru_reg; state_next = ST_RF_C0;
            end
            ST_RF_C0:
            begin
                w_next = rd_q;
                w_next.flow = rd_q.flow + FlowW'(rc_reg);
                w_next.bvalid = (rd_q.slots != '0);
                w_next.bcost = '0;
                w_next.bnode = (rd_q.slots != '0) ? ru_reg : '0;
                ch = {ru_reg, 1'b0};
                addr = ch[NodeW-1:0];
                state_next = ST_RF_C1;
            end
            ST_RF_C1:
            begin
                ch = {ru_reg, 1'b0};
                if (ch[NodeW] == 1'b0 && ch[NodeW-1:0] <= n_reg && rd_q.bvalid)
                begin
                    cand = rd_q.bcost + (rd_q.flow[FlowW-1] ? -8'sd1 : 8'sd1);
                    if (!w_reg.bvalid || cand <= w_reg.bcost)
                    begin
                        w_next.bvalid = 1'b1; w_next.bcost = cand; w_next.bnode = rd_q.bnode;
                    end
                end
                ch = {ru_reg, 1'b1};
                addr = ch[NodeW-1:0];
                state_next = ST_RF_WR;
            end
            ST_RF_WR:
            begin
                ch = {ru_reg, 1'b1};
                w_next = w_reg;
                if (ch[NodeW] == 1'b0 && ch[NodeW-1:0] <= n_reg && rd_q.bvalid)
                begin
                    cand = rd_q.bcost + (rd_q.flow[FlowW-1] ? -8'sd1 : 8'sd1);
                    if (!w_reg.bvalid || cand <= w_reg.bcost)
                    begin
                        w_next.bvalid = 1'b1; w_next.bcost = cand; w_next.bnode = rd_q.bnode;
                    end
                end
                wr_en = 1'b1; wr_addr = ru_reg; wr_d = w_next;
                rc_next = '0;
                state_next = ret_reg;
            end
            ST_OUT:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    ov_next = 1'b1;
                    out_next = found_reg ?
                        {1'b0, bn_reg, tot_reg, bc_reg[4:0]} :
                        {1'b0, 10'd0, tot_reg, 5'd0};
                    nf_next = !found_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `TNA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid, "result dropped while stalled")
    `TNA_ASSERT_IMP(a_no_take_busy, clk, rst_n, s_axis_tready,
        state_reg == ST_IDLE, "input taken while busy")
    `TNA_ASSERT_NEXT(a_clear_done, clk, rst_n,
        state_reg == ST_CLEAR && clr_reg == 10'd1023, state_reg == ST_IDLE,
        "clearing pass did not end")
endmodule
